/* hdl/sdpg_pkg.sv */
// Shared types and constants for the step/direction pulse generator.
`timescale 1ns / 1ps

package sdpg_pkg;

    // action codes carried in s_tuser
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SET_DIR = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;

    // configuration register indexes
    localparam logic REG_HALF_STEP_PERIOD = 1'b0;
    localparam logic REG_DISABLE_DELAY    = 1'b1;

    // register reset values
    localparam logic [31:0] RESET_HALF_STEP_PERIOD = 32'd10;
    localparam logic [31:0] RESET_DISABLE_DELAY    = 32'd3000;

    typedef struct packed {
        logic enable_n;
        logic dir_level;
        logic step_level;
    } sdpg_levels_t;

    typedef struct packed {
        logic went_enabled;
        logic went_disabled;
        logic direction_changed;
        logic step_toggled;
    } sdpg_events_t;

endpackage

/* hdl/sdpg_core.sv */
// Motor state registers and per-word next-state logic.
`timescale 1ns / 1ps

module sdpg_core #(
    parameter int COUNT_WIDTH = 24,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [1:0]                 action,
    input  logic                       new_direction,
    input  logic [COUNT_WIDTH-1:0]     pulse_count,
    input  logic [TIMER_WIDTH-1:0]     half_step_period,
    input  logic [TIMER_WIDTH-1:0]     disable_delay,
    output sdpg_pkg::sdpg_levels_t     levels,
    output logic [COUNT_WIDTH-1:0]     pulses_left,
    output sdpg_pkg::sdpg_events_t     events
);
    import sdpg_pkg::*;

    logic [COUNT_WIDTH-1:0] pending_reg, pending_next;
    logic                   step_reg, step_next;
    logic                   dir_reg, dir_next;
    logic                   powered_reg, powered_next;
    logic [TIMER_WIDTH-1:0] phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] hold_reg, hold_next;
    logic                   running_reg, running_next;

    logic [TIMER_WIDTH-1:0] hold_inc;
    logic [TIMER_WIDTH-1:0] phase_inc;

    assign hold_inc  = hold_reg + 1'b1;
    assign phase_inc = phase_reg + 1'b1;

    always_comb begin
        pending_next = pending_reg;
        step_next    = step_reg;
        dir_next     = dir_reg;
        powered_next = powered_reg;
        phase_next   = phase_reg;
        hold_next    = hold_reg;
        running_next = running_reg;
        events       = '0;

        case (action)
            ACT_TICK: begin
                // hold timer first
                if (running_reg) begin
                    if (hold_inc >= disable_delay || hold_inc == '0) begin
                        running_next = 1'b0;
                        hold_next    = '0;
                        if (powered_reg) begin
                            powered_next         = 1'b0;
                            events.went_disabled = 1'b1;
                        end
                    end else begin
                        hold_next = hold_inc;
                    end
                end
                // then phase timer
                if (phase_inc >= half_step_period || phase_inc == '0) begin
                    phase_next = '0;
                    if (pending_reg != '0) begin
                        running_next = 1'b0;
                        hold_next    = '0;
                        if (!powered_next) begin
                            powered_next        = 1'b1;
                            events.went_enabled = 1'b1;
                        end
                        step_next = ~step_reg;
                        if (step_next) begin
                            pending_next = pending_reg - 1'b1;
                        end
                        events.step_toggled = 1'b1;
                        if (pending_next == '0) begin
                            hold_next    = '0;
                            running_next = 1'b1;
                        end
                    end
                end else begin
                    phase_next = phase_inc;
                end
            end
            ACT_SET_DIR: begin
                if (new_direction != dir_reg) begin
                    pending_next             = '0;
                    hold_next                = '0;
                    running_next             = 1'b1;
                    dir_next                 = new_direction;
                    events.direction_changed = 1'b1;
                end
            end
            ACT_LOAD: begin
                pending_next = pulse_count;
                running_next = 1'b0;
                hold_next    = '0;
                if (!powered_reg) begin
                    powered_next        = 1'b1;
                    events.went_enabled = 1'b1;
                end
            end
            default: begin
            end
        endcase

        levels.enable_n   = ~powered_next;
        levels.dir_level  = dir_next;
        levels.step_level = step_next;
        pulses_left       = pending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            step_reg    <= 1'b1;
            dir_reg     <= 1'b0;
            powered_reg <= 1'b1;
            phase_reg   <= '0;
            hold_reg    <= '0;
            running_reg <= 1'b1;
        end else if (advance) begin
            pending_reg <= pending_next;
            step_reg    <= step_next;
            dir_reg     <= dir_next;
            powered_reg <= powered_next;
            phase_reg   <= phase_next;
            hold_reg    <= hold_next;
            running_reg <= running_next;
        end
    end

endmodule

/* hdl/step_dir_pulse_generator.sv */
// Top level of the step/direction pulse generator: registers, config port, output stage.
//
//  channel | dir | tdata (lsb up)                               | tuser
//  s_      | in  | new_direction, pulse_count                   | action
//  m_      | out | enable_n, dir_level, step_level, pulses_left,| -
//          |     | went_enabled, went_disabled,                 |
//          |     | direction_changed, step_toggled              |
//  cfg_    | in  | write: index 0 half_step_period, 1 disable_delay
//
// One word per cycle sustained while m_tready is high; each word's result is
// offered after passing from the input register into the result register.
// The state update happens as the input register moves into the result register.
// Reset is synchronous, active low; both word registers come out empty.
// A stall on m_tready backs up through the result register to s_tready.
`timescale 1ns / 1ps

module step_dir_pulse_generator #(
    parameter int COUNT_WIDTH = 24,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // new_direction, pulse_count
    input  logic [((COUNT_WIDTH+1+7)/8)*8-1:0]   s_tdata,
    // action
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // enable_n, dir_level, step_level, pulses_left, went_enabled,
    // went_disabled, direction_changed, step_toggled
    output logic [((COUNT_WIDTH+7+7)/8)*8-1:0]   m_tdata,
    input  logic                                 cfg_wen,
    input  logic                                 cfg_windex,
    input  logic [TIMER_WIDTH-1:0]               cfg_wdata
);
    import sdpg_pkg::*;

    localparam int OUT_W = ((COUNT_WIDTH + 7 + 7) / 8) * 8;

    logic [TIMER_WIDTH-1:0] period_reg;
    logic [TIMER_WIDTH-1:0] delay_reg;

    logic                   in_valid_reg;
    logic [1:0]             action_reg;
    logic                   dir_req_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    logic                   advance;
    sdpg_levels_t           levels;
    sdpg_events_t           events;
    logic [COUNT_WIDTH-1:0] pulses_left;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= TIMER_WIDTH'(RESET_HALF_STEP_PERIOD);
            delay_reg  <= TIMER_WIDTH'(RESET_DISABLE_DELAY);
        end else if (cfg_wen) begin
            if (cfg_windex == REG_HALF_STEP_PERIOD) begin
                period_reg <= cfg_wdata;
            end else begin
                delay_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            action_reg  <= s_tuser;
            dir_req_reg <= s_tdata[0];
            count_reg   <= s_tdata[COUNT_WIDTH:1];
        end
    end

    sdpg_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .action           (action_reg),
        .new_direction    (dir_req_reg),
        .pulse_count      (count_reg),
        .half_step_period (period_reg),
        .disable_delay    (delay_reg),
        .levels           (levels),
        .pulses_left      (pulses_left),
        .events           (events)
    );

    always_comb begin
        out_data_next                     = '0;
        out_data_next[0]                  = levels.enable_n;
        out_data_next[1]                  = levels.dir_level;
        out_data_next[2]                  = levels.step_level;
        out_data_next[COUNT_WIDTH+2:3]    = pulses_left;
        out_data_next[COUNT_WIDTH+3]      = events.went_enabled;
        out_data_next[COUNT_WIDTH+4]      = events.went_disabled;
        out_data_next[COUNT_WIDTH+5]      = events.direction_changed;
        out_data_next[COUNT_WIDTH+6]      = events.step_toggled;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* hdl/sdpg_checker.sv */
// Port-level checks for the step/direction pulse generator, bound to the top level.
`timescale 1ns / 1ps

module sdpg_checker #(
    parameter int COUNT_WIDTH = 24
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((COUNT_WIDTH+7+7)/8)*8-1:0] m_tdata
);

    // power-off event must leave the motor unpowered
    a_disable_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[COUNT_WIDTH+4] |-> m_tdata[0])
        else $error("went_disabled with motor still powered");

    // power-on event must leave the motor powered
    a_enable_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[COUNT_WIDTH+3] |-> !m_tdata[0])
        else $error("went_enabled with motor unpowered");

    // a step toggle only happens with the motor powered
    a_step_powered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[COUNT_WIDTH+6] |-> !m_tdata[0])
        else $error("step toggled while unpowered");

    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed under stall");

endmodule

bind step_dir_pulse_generator sdpg_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_sdpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
